// ===== hdl/rtcbi_pkg.sv =====
package rtcbi_pkg;

  localparam int STORE_BYTES_DEF  = 24576;
  localparam int MAX_BYTE_DIM_DEF = 255;

  localparam logic [14:0] AREA_LIMIT_RESET = 15'd24576;

  // Input word kinds.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_EMIT  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DIM  = 2'd1;
  localparam logic [1:0] STAT_AREA = 2'd2;
  localparam logic [1:0] STAT_SEQ  = 2'd3;

  // Command header bytes and their positions in the output stream.
  localparam logic [7:0] CMD_GS   = 8'd29;
  localparam logic [7:0] CMD_STAR = 8'd42;

  localparam logic [1:0] HDR_POS_GS   = 2'd0;
  localparam logic [1:0] HDR_POS_STAR = 2'd1;
  localparam logic [1:0] HDR_POS_COLS = 2'd2;
  localparam logic [1:0] HDR_POS_ROWS = 2'd3;

  typedef struct packed {
    logic start;     // check and load a new image
    logic pix_rd;    // read the store byte the pixel lands in
    logic pix_wr;    // merge the pixel and write the byte back
    logic hdr_out;   // emit a header byte
    logic data_rd;   // read the next data byte
    logic data_out;  // emit the data byte read last cycle
    logic err_out;   // emit an out-of-sequence status
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic start_ok;
    logic start_empty;
    logic pix_last;
    logic emit_is_hdr;
    logic emit_last;
  } stat_t;

endpackage

// ===== hdl/rtcbi_ctrl.sv =====
module rtcbi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [1:0]          kind,
  input  rtcbi_pkg::stat_t    stat,
  output rtcbi_pkg::cmd_t     cmd
);
  import rtcbi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RECV,
    S_PIXW,
    S_EMIT,
    S_EMITRD
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = ((state == S_IDLE) || (state == S_RECV) || (state == S_EMIT)) &&
                    stat.out_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_PIXW: begin
        cmd.pix_wr = 1'b1;
        state_next = stat.pix_last ? S_EMIT : S_RECV;
      end
      S_EMITRD: begin
        cmd.data_out = 1'b1;
        state_next   = stat.emit_last ? S_IDLE : S_EMIT;
      end
      S_IDLE, S_RECV, S_EMIT: begin
        if (accept) begin
          priority case (kind)
            KIND_START: begin
              cmd.start = 1'b1;
              if (!stat.start_ok) begin
                state_next = S_IDLE;
              end else if (stat.start_empty) begin
                state_next = S_EMIT;
              end else begin
                state_next = S_RECV;
              end
            end
            KIND_PIXEL: begin
              if (state == S_RECV) begin
                cmd.pix_rd = 1'b1;
                state_next = S_PIXW;
              end else begin
                cmd.err_out = 1'b1;
              end
            end
            KIND_EMIT: begin
              if (state != S_EMIT) begin
                cmd.err_out = 1'b1;
              end else if (stat.emit_is_hdr) begin
                cmd.hdr_out = 1'b1;
                state_next  = stat.emit_last ? S_IDLE : S_EMIT;
              end else begin
                cmd.data_rd = 1'b1;
                state_next  = S_EMITRD;
              end
            end
            default: begin
              cmd.err_out = 1'b1;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/rtcbi_datapath.sv =====
module rtcbi_datapath #(
  parameter int STORE_BYTES  = rtcbi_pkg::STORE_BYTES_DEF,
  parameter int MAX_BYTE_DIM = rtcbi_pkg::MAX_BYTE_DIM_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [14:0]         cfg_wr_data,
  input  logic                in_pixel,
  input  logic [11:0]         in_width,
  input  logic [11:0]         in_height,
  input  rtcbi_pkg::cmd_t     cmd,
  output rtcbi_pkg::stat_t    stat,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [15:0]         m_tdata,
  output logic                m_tlast
);
  import rtcbi_pkg::*;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int IDX_W  = $clog2(STORE_BYTES + 5);

  logic [14:0]       area_limit;
  logic [10:0]       width_px;
  logic [10:0]       height_px;
  logic [7:0]        byte_cols;
  logic [7:0]        byte_rows;
  logic [10:0]       pixel_col;
  logic [10:0]       pixel_row;
  logic [ADDR_W-1:0] wr_idx;
  logic [IDX_W-1:0]  emit_index;
  logic [IDX_W-1:0]  emit_total;
  logic [7:0]        emit_row;
  logic [10:0]       emit_col;
  logic [7:0]        pix_bit;
  logic              pix_fresh;

  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        rdata;
  logic [ADDR_W-1:0] data_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;
  logic [7:0]        wr_data;

  logic [12:0]       w_sum;
  logic [12:0]       h_sum;
  logic [9:0]        cols_calc;
  logic [9:0]        rows_calc;
  logic [19:0]       area_prod;
  logic [22:0]       area;
  logic              dim_err;
  logic              area_err;
  logic [1:0]        start_status;

  logic [10:0]       col_inc;
  logic [10:0]       row_inc;
  logic [7:0]        hdr_byte;
  logic [7:0]        data_byte;
  logic              load;

  // Start checks on the incoming dimensions.
  assign w_sum     = {1'b0, in_width} + 13'd7;
  assign h_sum     = {1'b0, in_height} + 13'd7;
  assign cols_calc = w_sum[12:3];
  assign rows_calc = h_sum[12:3];
  assign area_prod = cols_calc * rows_calc;
  assign area      = {area_prod, 3'b000};
  assign dim_err   = (cols_calc > 10'(MAX_BYTE_DIM)) || (rows_calc > 10'(MAX_BYTE_DIM));
  assign area_err  = (area > {8'd0, area_limit}) || (area > 23'(STORE_BYTES));

  always_comb begin
    if (dim_err) begin
      start_status = STAT_DIM;
    end else if (area_err) begin
      start_status = STAT_AREA;
    end else begin
      start_status = STAT_OK;
    end
  end

  assign col_inc = pixel_col + 11'd1;
  assign row_inc = pixel_row + 11'd1;

  assign stat.out_free    = !m_tvalid || m_tready;
  assign stat.start_ok    = !dim_err && !area_err;
  assign stat.start_empty = (in_width == 12'd0) || (in_height == 12'd0);
  assign stat.pix_last    = (col_inc == width_px) && (row_inc == height_px);
  assign stat.emit_is_hdr = emit_index < IDX_W'(4);
  assign stat.emit_last   = (emit_index + IDX_W'(1)) == emit_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_limit <= AREA_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      area_limit <= cfg_wr_data;
    end
  end

  // Image geometry and the receive and emit counters.
  always_ff @(posedge clk) begin
    if (cmd.start && stat.start_ok) begin
      width_px   <= in_width[10:0];
      height_px  <= in_height[10:0];
      byte_cols  <= cols_calc[7:0];
      byte_rows  <= rows_calc[7:0];
      pixel_col  <= '0;
      pixel_row  <= '0;
      wr_idx     <= '0;
      emit_index <= '0;
      emit_total <= IDX_W'(area) + IDX_W'(4);
      emit_row   <= '0;
      emit_col   <= '0;
    end else begin
      if (cmd.pix_wr) begin
        if (col_inc == width_px) begin
          pixel_col <= '0;
          pixel_row <= row_inc;
          wr_idx    <= ADDR_W'(row_inc[10:3]);
        end else begin
          pixel_col <= col_inc;
          wr_idx    <= wr_idx + ADDR_W'(byte_rows);
        end
      end
      if (cmd.hdr_out || cmd.data_out) begin
        emit_index <= emit_index + IDX_W'(1);
      end
      if (cmd.data_out) begin
        if ((emit_row + 8'd1) == byte_rows) begin
          emit_row <= '0;
          emit_col <= emit_col + 11'd1;
        end else begin
          emit_row <= emit_row + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_rd) begin
      pix_bit   <= 8'(in_pixel) << (3'd7 - pixel_row[2:0]);
      pix_fresh <= (pixel_row[2:0] == 3'd0);
    end
  end

  // Image store: one write and one registered read per cycle.
  assign data_addr = ADDR_W'(emit_index - IDX_W'(4));
  assign rd_addr   = cmd.pix_rd ? wr_idx : data_addr;
  assign rd_en     = cmd.pix_rd || cmd.data_rd;
  assign wr_data   = (pix_fresh ? 8'h00 : rdata) | pix_bit;

  always_ff @(posedge clk) begin
    if (cmd.pix_wr) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    unique case (emit_index[1:0])
      HDR_POS_GS:   hdr_byte = CMD_GS;
      HDR_POS_STAR: hdr_byte = CMD_STAR;
      HDR_POS_COLS: hdr_byte = byte_cols;
      HDR_POS_ROWS: hdr_byte = byte_rows;
    endcase
  end

  // Bytes of columns in the width padding are never stored.
  assign data_byte = (emit_col >= width_px) ? 8'h00 : rdata;

  assign load = cmd.start || cmd.err_out || cmd.hdr_out || cmd.data_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (cmd.hdr_out) begin
        m_tdata <= {6'd0, STAT_OK, hdr_byte};
        m_tlast <= stat.emit_last;
      end else if (cmd.data_out) begin
        m_tdata <= {6'd0, STAT_OK, data_byte};
        m_tlast <= stat.emit_last;
      end else if (cmd.start) begin
        m_tdata <= {6'd0, start_status, 8'h00};
        m_tlast <= 1'b0;
      end else begin
        m_tdata <= {6'd0, STAT_SEQ, 8'h00};
        m_tlast <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/raster_to_column_bit_image.sv =====
// Start, sequence-error and header words give their result in the cycle after acceptance.
// A pixel word is a store read, then the merged write-back, during which input is stalled.
// A data byte stalls input as it passes the registered store read, then the output register.
// Sustained rate: one word per cycle for header and status words while the output is free.
// Synchronous active-high reset returns to idle, drops the output word and restores the area
// limit to 24576; the image store is not cleared, since no unwritten byte's value is ever used.
module raster_to_column_bit_image #(
  parameter int STORE_BYTES  = rtcbi_pkg::STORE_BYTES_DEF,
  parameter int MAX_BYTE_DIM = rtcbi_pkg::MAX_BYTE_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Area limit register, written whenever cfg_wr_en is high.
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  // Input words.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [0] pixel_on, [12:1] image_width, [24:13] image_height
  input  logic [1:0]  s_tuser,   // [1:0] kind
  // Result words.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] status
  output logic        m_tlast    // last_byte
);
  import rtcbi_pkg::*;

  // The controller sequences each word: it decides from the word kind and the
  // current phase (idle, receiving pixels, emitting) which datapath commands
  // fire, and holds off new words while the output word is still held, during the
  // write-back of a pixel read-modify-write and while a data byte read is emitted.
  cmd_t  cmd;
  stat_t stat;

  rtcbi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .kind     (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the image geometry, the receive and emit counters, the
  // image store and the output word register. Pixel addresses are walked with
  // a running index (one byte row stride per pixel) rather than multiplied, and
  // the emit side tracks its column so width padding reads as zero.
  rtcbi_datapath #(
    .STORE_BYTES  (STORE_BYTES),
    .MAX_BYTE_DIM (MAX_BYTE_DIM)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_pixel    (s_tdata[0]),
    .in_width    (s_tdata[12:1]),
    .in_height   (s_tdata[24:13]),
    .cmd         (cmd),
    .stat        (stat),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule
